[rtl/tup_pkg.sv]
package tup_pkg;

    typedef enum logic [1:0] {
        UNIT_UNKNOWN    = 2'd0,
        UNIT_CELSIUS    = 2'd1,
        UNIT_FAHRENHEIT = 2'd2
    } tup_unit_t;

    localparam int unsigned BLOCK_LEN = 11;
    localparam logic [8*BLOCK_LEN-1:0] BLOCK_TEXT = "FDFILEBLOCK";

    localparam int unsigned C_LEN = 7;
    localparam logic [8*C_LEN-1:0] C_WORD = "celsius";

    localparam int unsigned F_LEN = 10;
    localparam logic [8*F_LEN-1:0] F_WORD = "fahrenheit";

    localparam logic [7:0] BLANK_MAX = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CASE_GAP  = 8'd32;

    typedef struct packed {
        logic       step;
        logic       close;
        logic       letter;
        logic       prev_letter;
        logic [7:0] low;
    } tup_sym_t;

endpackage

[rtl/tup_word_match.sv]
module tup_word_match
    import tup_pkg::*;
#(
    parameter int unsigned WLEN = 7,
    parameter logic [8*WLEN-1:0] WORD = "celsius"
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  tup_sym_t sym,
    output logic     found
);

    localparam int unsigned IW = $clog2(WLEN + 1);

    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic          found_reg;
    logic          adv;
    logic          first_hit;
    logic          ended;
    logic          hit;

    always_comb begin
        adv = 1'b0;
        for (int i = 1; i < WLEN; i++) begin
            if (idx_reg == IW'(i) && sym.low == WORD[8*(WLEN-1-i) +: 8]) begin
                adv = 1'b1;
            end
        end
        first_hit = (sym.low == WORD[8*(WLEN-1) +: 8]);
        if (!sym.letter) begin
            idx_next = '0;
        end else if (!sym.prev_letter) begin
            idx_next = first_hit ? IW'(1) : '0;
        end else if (adv) begin
            idx_next = idx_reg + IW'(1);
        end else begin
            idx_next = '0;
        end
        ended = !sym.letter && (idx_reg == IW'(WLEN));
        hit   = sym.letter ? (idx_next == IW'(WLEN)) : ended;
        found = found_reg | hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end else if (sym.step) begin
            if (sym.close) begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end else begin
                idx_reg   <= idx_next;
                found_reg <= found_reg | ended;
            end
        end
    end

endmodule

[rtl/temperature_unit_record_parser.sv]
// Channel  | Ports                                  | Moves
// s_       | s_valid s_ready s_rx_byte             | one record byte per transfer,
//          | s_end_of_record                        | last byte flagged
// m_       | m_valid m_ready m_unit_code            | one unit code per record
//
// One byte per cycle unless the last byte waits for the result slot: input register, then
// the scan stage updates the trim, prefix and word matchers and loads the result register
// on the last byte. m_valid rises once the scan stage has loaded the result register.
// aresetn is synchronous, active low, and clears all record state.
// A stalled result holds the next record's last byte and s_ready; its earlier bytes flow.
module temperature_unit_record_parser
    import tup_pkg::*;
#(
    parameter int unsigned MAX_LEN = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_end_of_record,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_unit_code
);

    localparam int unsigned LEN_CAP = MAX_LEN + 1;
    localparam int unsigned LW      = $clog2(MAX_LEN + 2);
    localparam int unsigned PW      = $clog2(BLOCK_LEN + 1);

    logic        pipe_valid_reg;
    logic [7:0]  pipe_byte_reg;
    logic        pipe_last_reg;

    logic        m_valid_reg;
    tup_unit_t   m_unit_reg;

    logic          seen_reg, seen_next;
    logic [LW-1:0] run_reg, run_next;
    logic [LW-1:0] tlen_reg, tlen_next;
    logic [PW-1:0] pidx_reg, pidx_next;
    logic          pmatch_reg, pmatch_next;
    logic [7:0]    first_reg, first_next;
    logic [7:0]    second_reg, second_next;
    logic          prev_letter_reg;

    logic          out_free;
    logic          proc;
    logic          content;
    logic          upper;
    logic          mismatch;
    logic [LW:0]   tsum;
    tup_sym_t      sym;
    logic          c_found;
    logic          f_found;
    tup_unit_t     code;

    assign out_free = !m_valid_reg || m_ready;
    assign proc     = pipe_valid_reg && (!pipe_last_reg || out_free);
    assign s_ready  = !pipe_valid_reg || proc;

    assign m_valid     = m_valid_reg;
    assign m_unit_code = m_unit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_valid_reg <= 1'b0;
        end else if (s_ready) begin
            pipe_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            pipe_byte_reg <= s_rx_byte;
            pipe_last_reg <= s_end_of_record;
        end
    end

    always_comb begin
        content = pipe_byte_reg > BLANK_MAX;
        upper   = pipe_byte_reg inside {[8'h41:8'h5A]};

        sym.step        = proc;
        sym.close       = pipe_last_reg;
        sym.letter      = upper || (pipe_byte_reg inside {[8'h61:8'h7A]});
        sym.prev_letter = prev_letter_reg;
        sym.low         = upper ? pipe_byte_reg + CASE_GAP : pipe_byte_reg;

        mismatch = 1'b0;
        for (int i = 1; i < BLOCK_LEN; i++) begin
            if (pidx_reg == PW'(i) &&
                pipe_byte_reg != BLOCK_TEXT[8*(BLOCK_LEN-1-i) +: 8]) begin
                mismatch = 1'b1;
            end
        end

        tsum = {1'b0, tlen_reg} + {1'b0, run_reg} + (LW+1)'(1);

        seen_next   = seen_reg;
        run_next    = run_reg;
        tlen_next   = tlen_reg;
        pidx_next   = pidx_reg;
        pmatch_next = pmatch_reg;
        first_next  = first_reg;
        second_next = second_reg;

        if (content && !seen_reg) begin
            seen_next   = 1'b1;
            first_next  = pipe_byte_reg;
            tlen_next   = LW'(1);
            run_next    = '0;
            pmatch_next = (pipe_byte_reg == BLOCK_TEXT[8*BLOCK_LEN-1 -: 8]);
            pidx_next   = PW'(1);
        end else if (seen_reg) begin
            if (pidx_reg == PW'(1)) begin
                second_next = pipe_byte_reg;
            end
            if (pidx_reg < PW'(BLOCK_LEN)) begin
                if (mismatch) begin
                    pmatch_next = 1'b0;
                end
                pidx_next = pidx_reg + PW'(1);
            end
            if (content) begin
                tlen_next = (tsum > (LW+1)'(LEN_CAP)) ? LW'(LEN_CAP) : tsum[LW-1:0];
                run_next  = '0;
            end else if (run_reg < LW'(LEN_CAP)) begin
                run_next = run_reg + LW'(1);
            end
        end

        if (!seen_next || tlen_next > LW'(MAX_LEN)) begin
            code = UNIT_UNKNOWN;
        end else if (pidx_next == PW'(BLOCK_LEN) && pmatch_next) begin
            code = UNIT_UNKNOWN;
        end else if (c_found && !f_found) begin
            code = UNIT_CELSIUS;
        end else if (f_found && !c_found) begin
            code = UNIT_FAHRENHEIT;
        end else if (c_found && f_found) begin
            code = UNIT_UNKNOWN;
        end else if (tlen_next >= LW'(2) && second_next == CH_COMMA &&
                     first_next == CH_ZERO) begin
            code = UNIT_CELSIUS;
        end else if (tlen_next >= LW'(2) && second_next == CH_COMMA &&
                     first_next == CH_ONE) begin
            code = UNIT_FAHRENHEIT;
        end else begin
            code = UNIT_UNKNOWN;
        end
    end

    tup_word_match #(
        .WLEN (C_LEN),
        .WORD (C_WORD)
    ) u_celsius (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sym     (sym),
        .found   (c_found)
    );

    tup_word_match #(
        .WLEN (F_LEN),
        .WORD (F_WORD)
    ) u_fahrenheit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sym     (sym),
        .found   (f_found)
    );

    // record state; clear on the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg        <= 1'b0;
            run_reg         <= '0;
            tlen_reg        <= '0;
            pidx_reg        <= '0;
            pmatch_reg      <= 1'b1;
            first_reg       <= '0;
            second_reg      <= '0;
            prev_letter_reg <= 1'b0;
        end else if (proc) begin
            if (pipe_last_reg) begin
                seen_reg        <= 1'b0;
                run_reg         <= '0;
                tlen_reg        <= '0;
                pidx_reg        <= '0;
                pmatch_reg      <= 1'b1;
                first_reg       <= '0;
                second_reg      <= '0;
                prev_letter_reg <= 1'b0;
            end else begin
                seen_reg        <= seen_next;
                run_reg         <= run_next;
                tlen_reg        <= tlen_next;
                pidx_reg        <= pidx_next;
                pmatch_reg      <= pmatch_next;
                first_reg       <= first_next;
                second_reg      <= second_next;
                prev_letter_reg <= sym.letter;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc && pipe_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && pipe_last_reg) begin
            m_unit_reg <= code;
        end
    end

`ifndef SYNTH
    a_close_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && pipe_last_reg |=> m_valid)
        else $error("record close did not load a result");

    a_last_waits_for_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_valid_reg && pipe_last_reg && m_valid_reg && !m_ready |-> !proc && !s_ready)
        else $error("last byte processed while result slot full");

    a_close_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && pipe_last_reg |=> !seen_reg && tlen_reg == '0 && pidx_reg == '0)
        else $error("record state not cleared after close");

    a_length_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        tlen_reg <= LW'(LEN_CAP) && run_reg <= LW'(LEN_CAP))
        else $error("length counter past saturation");
`endif

endmodule

[dv/temperature_unit_record_parser_checker.sv]
module temperature_unit_record_parser_checker
    import tup_pkg::*;
#(
    parameter int unsigned MAX_LEN = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_end_of_record,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [1:0] m_unit_code,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LEN_CAP = MAX_LEN + 1;

    bit          seen_content;
    int unsigned blank_run;
    int unsigned trim_len;
    logic [3:0]  prefix_pos;
    bit          prefix_ok;
    logic [7:0]  first_ch;
    logic [7:0]  second_ch;
    bit          prev_letter;
    logic [2:0]  c_pos;
    logic [3:0]  f_pos;
    bit          c_found;
    bit          f_found;
    tup_unit_t   unit_q[$];

    function automatic bit is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + CASE_GAP : b;
    endfunction

    task automatic clear_record();
        seen_content = 1'b0;
        blank_run    = 0;
        trim_len     = 0;
        prefix_pos   = '0;
        prefix_ok    = 1'b1;
        first_ch     = '0;
        second_ch    = '0;
        prev_letter  = 1'b0;
        c_pos        = '0;
        f_pos        = '0;
        c_found      = 1'b0;
        f_found      = 1'b0;
    endtask

    task automatic scan_byte(input logic [7:0] b, input bit last);
        bit          content;
        logic [7:0]  low;
        int unsigned span;
        tup_unit_t   unit;
        content = b > BLANK_MAX;
        if (content && !seen_content) begin
            seen_content = 1'b1;
            first_ch     = b;
            trim_len     = 1;
            blank_run    = 0;
            prefix_ok    = (b == BLOCK_TEXT[8*(BLOCK_LEN-1) +: 8]);
            prefix_pos   = 4'd1;
        end else if (seen_content) begin
            if (prefix_pos == 4'd1) begin
                second_ch = b;
            end
            if (prefix_pos < BLOCK_LEN) begin
                if (b != BLOCK_TEXT[8*(BLOCK_LEN-1-prefix_pos) +: 8]) begin
                    prefix_ok = 1'b0;
                end
                prefix_pos++;
            end
            if (content) begin
                span      = trim_len + blank_run + 1;
                trim_len  = (span > LEN_CAP) ? LEN_CAP : span;
                blank_run = 0;
            end else if (blank_run < LEN_CAP) begin
                blank_run++;
            end
        end

        if (is_alpha(b)) begin
            low = fold_case(b);
            if (!prev_letter) begin
                c_pos = (low == C_WORD[8*(C_LEN-1) +: 8]) ? 3'd1 : 3'd0;
                f_pos = (low == F_WORD[8*(F_LEN-1) +: 8]) ? 4'd1 : 4'd0;
            end else begin
                if (c_pos > 0 && c_pos < C_LEN && low == C_WORD[8*(C_LEN-1-c_pos) +: 8]) begin
                    c_pos++;
                end else begin
                    c_pos = '0;
                end
                if (f_pos > 0 && f_pos < F_LEN && low == F_WORD[8*(F_LEN-1-f_pos) +: 8]) begin
                    f_pos++;
                end else begin
                    f_pos = '0;
                end
            end
            prev_letter = 1'b1;
        end else begin
            if (c_pos == C_LEN) begin
                c_found = 1'b1;
            end
            if (f_pos == F_LEN) begin
                f_found = 1'b1;
            end
            c_pos       = '0;
            f_pos       = '0;
            prev_letter = 1'b0;
        end

        if (last) begin
            if (c_pos == C_LEN) begin
                c_found = 1'b1;
            end
            if (f_pos == F_LEN) begin
                f_found = 1'b1;
            end
            if (!seen_content || trim_len == 0 || trim_len > MAX_LEN) begin
                unit = UNIT_UNKNOWN;
            end else if (prefix_pos == BLOCK_LEN && prefix_ok) begin
                unit = UNIT_UNKNOWN;
            end else if (c_found && !f_found) begin
                unit = UNIT_CELSIUS;
            end else if (f_found && !c_found) begin
                unit = UNIT_FAHRENHEIT;
            end else if (c_found && f_found) begin
                unit = UNIT_UNKNOWN;
            end else if (trim_len >= 2 && second_ch == CH_COMMA &&
                         (first_ch == CH_ZERO || first_ch == CH_ONE)) begin
                unit = (first_ch == CH_ZERO) ? UNIT_CELSIUS : UNIT_FAHRENHEIT;
            end else begin
                unit = UNIT_UNKNOWN;
            end
            unit_q.push_back(unit);
            clear_record();
        end
    endtask

    always @(posedge aclk) begin
        tup_unit_t want;
        if (!aresetn) begin
            clear_record();
            unit_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (unit_q.size() == 0) begin
                    $error("unit_code: no transfer expected, actual %0d", m_unit_code);
                    fail_count++;
                end else begin
                    want = unit_q.pop_front();
                    if (m_unit_code !== want) begin
                        $error("unit_code: expected %0d, actual %0d", want, m_unit_code);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                scan_byte(s_rx_byte, s_end_of_record);
            end
        end
        pending = unit_q.size();
    end

endmodule

[dv/tb_temperature_unit_record_parser.sv]
module tb_temperature_unit_record_parser
    import tup_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RECORD_MAX = 64;

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic [7:0] s_rx_byte       = 8'h00;
    logic       s_end_of_record = 1'b0;
    logic       m_ready         = 1'b0;
    wire        s_ready;
    wire        m_valid;
    wire  [1:0] m_unit_code;

    int         fail_count;
    int         pending;
    int         idle_pct      = 0;
    int         stall_pct     = 0;
    bit         hold_request  = 1'b0;
    int         phase_bytes;
    int         phase_records;
    logic [7:0] rec[$];

    string seps       = " ,.;:=/0123456789()-_";
    string fillers[]  = '{"t=", "22.5", " deg ", "unit:", "temp", "#", "C", "F", "cel",
                          "fahr", "sius", "-40", "ok"};
    string near_miss[] = '{"celsiu", "celsiuss", "xcelsius", "fahrenhei", "fahrenheitt",
                           "cels ius", "fahren heit", "celfahrenheit", "celsiusfahrenheit"};
    string block_var[] = '{"FDFILEBLOCK", "FDFILEBLOCK celsius", "FDFILEBLOCK,1,",
                           "FDFILEBLOC celsius", "fdfileblock celsius", "XFDFILEBLOCK 1,",
                           "FDF", "FDFILEBLOCKfahrenheit", "FDFILEBLOCKX"};

    temperature_unit_record_parser #(
        .MAX_LEN (RECORD_MAX)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_end_of_record (s_end_of_record),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_unit_code     (m_unit_code)
    );

    temperature_unit_record_parser_checker #(
        .MAX_LEN (RECORD_MAX)
    ) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_end_of_record (s_end_of_record),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_unit_code     (m_unit_code),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #1ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_done) begin
                hold_left = 200;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic put_text(input string txt, input bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < txt.len(); i++) begin
            c = txt[i];
            if (mix_case && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
                $urandom_range(0, 1)) begin
                c = c ^ CASE_GAP;
            end
            rec.push_back(c);
        end
    endtask

    task automatic put_blanks(input int n);
        repeat (n) rec.push_back(8'($urandom_range(0, 32)));
    endtask

    task automatic put_noise(input int n);
        repeat (n) rec.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_edge_char();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            rec.push_back(seps[$urandom_range(0, seps.len() - 1)]);
        end else if (pick == 9) begin
            rec.push_back(8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25)));
        end
    endtask

    task automatic put_word(input string w);
        put_edge_char();
        put_text(w, 1'b1);
        put_edge_char();
    endtask

    task automatic put_filler();
        repeat ($urandom_range(0, 2))
            put_text(fillers[$urandom_range(0, fillers.size() - 1)], 1'b1);
    endtask

    task automatic make_record();
        int kind;
        int len;
        bit gap_fill;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 3) begin
            put_blanks($urandom_range(1, 4));
        end
        if (kind < 15) begin
            case ($urandom_range(0, 3))
                0: rec.push_back(CH_ZERO);
                1: rec.push_back(CH_ONE);
                2: rec.push_back($urandom_range(0, 1) ? CH_ZERO : CH_ONE);
                default: rec.push_back(8'($urandom_range(33, 255)));
            endcase
            if ($urandom_range(0, 4) != 0) begin
                rec.push_back(CH_COMMA);
            end else begin
                rec.push_back(8'($urandom_range(0, 255)));
            end
            put_filler();
        end else if (kind < 35) begin
            put_filler();
            put_word("celsius");
            put_filler();
        end else if (kind < 55) begin
            put_filler();
            put_word("fahrenheit");
            put_filler();
        end else if (kind < 62) begin
            put_word($urandom_range(0, 1) ? "celsius" : "fahrenheit");
            put_filler();
            put_word($urandom_range(0, 1) ? "celsius" : "fahrenheit");
        end else if (kind < 70) begin
            put_filler();
            put_word(near_miss[$urandom_range(0, near_miss.size() - 1)]);
        end else if (kind < 76) begin
            put_text(block_var[$urandom_range(0, block_var.size() - 1)], 1'b0);
            if ($urandom_range(0, 1)) begin
                put_word("fahrenheit");
            end
        end else if (kind < 80) begin
            len = ($urandom_range(0, 3) != 0) ? $urandom_range(RECORD_MAX - 2, RECORD_MAX + 3)
                                              : $urandom_range(2, 140);
            gap_fill = ($urandom_range(0, 9) < 3);
            rec.push_back(8'($urandom_range(33, 255)));
            repeat (len - 2)
                rec.push_back(gap_fill ? 8'($urandom_range(0, 32)) : 8'($urandom_range(0, 255)));
            rec.push_back(8'($urandom_range(33, 255)));
        end else if (kind < 85) begin
            put_blanks($urandom_range(1, 6));
        end else begin
            put_noise($urandom_range(1, 12));
        end
        if ($urandom_range(0, 9) < 3) begin
            put_blanks($urandom_range(1, 4));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid         <= 1'b0;
            s_rx_byte       <= 8'($urandom_range(0, 255));
            s_end_of_record <= 1'($urandom_range(0, 1));
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_rx_byte       <= b;
        s_end_of_record <= last;
        do @(posedge aclk); while (!s_ready);
        phase_bytes++;
    endtask

    task automatic send_record();
        if (rec.size() == 0) begin
            rec.push_back(BLANK_MAX);
        end
        foreach (rec[i]) begin
            send_byte(rec[i], i == rec.size() - 1);
        end
        rec.delete();
        phase_records++;
    endtask

    task automatic send_text(input string txt);
        put_text(txt, 1'b0);
        send_record();
    endtask

    initial begin
        int drain;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_text("celsius");
        send_text("FAHRENHEIT");
        send_text("0,");
        send_text("1,5");
        send_text("2,x");
        send_text("celsius fahrenheit");
        send_text("xcelsius");
        send_text("FDFILEBLOCK");
        send_text("FDFILEBLOCK celsius");
        rec.push_back(8'h00);
        rec.push_back(BLANK_MAX);
        send_record();
        rec.push_back(8'h21);
        send_record();
        rec.push_back(8'hFF);
        send_record();
        rec.push_back(8'h01);
        put_text("1,", 1'b0);
        rec.push_back(BLANK_MAX);
        send_record();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                3: begin idle_pct = 25; stall_pct = 25; end
                default: begin
                    idle_pct     = 0;
                    stall_pct    = 0;
                    hold_request = 1'b1;
                end
            endcase
            phase_bytes   = 0;
            phase_records = 0;
            while (phase_bytes < 60 || phase_records < 4) begin
                make_record();
                send_record();
            end
        end
        s_valid <= 1'b0;

        drain = 0;
        @(negedge aclk);
        while (pending != 0 && drain < 20000) begin
            @(negedge aclk);
            drain++;
        end
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[temperature_unit_record_parser.f]
rtl/tup_pkg.sv
rtl/tup_word_match.sv
rtl/temperature_unit_record_parser.sv
dv/temperature_unit_record_parser_checker.sv
dv/tb_temperature_unit_record_parser.sv
